[rtl/core/tsq_pkg.sv]
// Package for the triangle shape quality pipeline.
// Holds the fixed widths, the item sideband type and the coordinate type.
// Used by every module in rtl/core.
package tsq_pkg;

   localparam int COORD_BITS        = 24;
   localparam int QUALITY_FRAC_BITS = 16;
   localparam int ID_W              = 16;

   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int MAG_W   = PROD_W - 1;
   localparam int HALF_W  = (MAG_W + 1) / 2;
   localparam int HI_W    = MAG_W - HALF_W;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int NORM_W  = SQ_W + 2;
   localparam int EDGE_W  = PROD_W + 2;
   localparam int X_W     = NORM_W + 4 + 2 * QUALITY_FRAC_BITS;
   localparam int R_W     = X_W / 2;
   localparam int RM_W    = R_W + 2;
   localparam int DV_W    = R_W + 1;
   localparam int QUO_W   = QUALITY_FRAC_BITS + 1;
   localparam int GEOM_STAGES = 6;

   localparam logic [QUO_W-1:0] QUALITY_ONE = QUO_W'(1) << QUALITY_FRAC_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic            valid;
      logic            degen;
      logic [ID_W-1:0] id;
   } side_type;

endpackage

[rtl/core/tsq_geom.sv]
// Geometry front end: edge vectors, cross product and edge lengths.
// Produces the squared cross norm and the squared edge sum in six stages.
// Depends on tsq_pkg.
module tsq_geom (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  tsq_pkg::side_type               in_side,
   input  tsq_pkg::coord_type              in_pts [3][3],
   output tsq_pkg::side_type               out_side,
   output logic [tsq_pkg::NORM_W-1:0]      out_norm,
   output logic [tsq_pkg::EDGE_W-1:0]      out_edge
);
   import tsq_pkg::*;

   side_type                  sd_ff [GEOM_STAGES];
   logic signed [DIFF_W-1:0]  dif_ff [3][3];
   logic signed [PROD_W-1:0]  crs_ff [3][2];
   logic [PROD_W-1:0]         esq_ff [3][3];
   logic [PROD_W:0]           cd_in [3];
   logic [PROD_W:0]           ca_in [3];
   logic [MAG_W-1:0]          mag_ff [3];
   logic [EDGE_W-1:0]         esum_ff [3];
   logic [HI_W-1:0]           hi_in [3];
   logic [HALF_W-1:0]         lo_in [3];
   logic [2*HI_W-1:0]         hh_ff [3];
   logic [HI_W+HALF_W-1:0]    hl_ff [3];
   logic [2*HALF_W-1:0]       ll_ff [3];
   logic [EDGE_W-1:0]         edge4_ff, edge5_ff, edge6_ff;
   logic [SQ_W-1:0]           sq_ff [3];
   logic [NORM_W-1:0]         norm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GEOM_STAGES; i++) sd_ff[i].valid <= 1'b0;
      end else if (en) begin
         sd_ff[0] <= in_side;
         for (int i = 1; i < GEOM_STAGES; i++) sd_ff[i] <= sd_ff[i-1];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cd_in[i] = {crs_ff[i][0][PROD_W-1], crs_ff[i][0]}
                  - {crs_ff[i][1][PROD_W-1], crs_ff[i][1]};
         ca_in[i] = cd_in[i][PROD_W] ? (~cd_in[i] + 1'b1) : cd_in[i];
         hi_in[i] = mag_ff[i][MAG_W-1:HALF_W];
         lo_in[i] = mag_ff[i][HALF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            dif_ff[0][k] <= {in_pts[1][k][COORD_BITS-1], in_pts[1][k]}
                          - {in_pts[0][k][COORD_BITS-1], in_pts[0][k]};
            dif_ff[1][k] <= {in_pts[2][k][COORD_BITS-1], in_pts[2][k]}
                          - {in_pts[0][k][COORD_BITS-1], in_pts[0][k]};
            dif_ff[2][k] <= {in_pts[2][k][COORD_BITS-1], in_pts[2][k]}
                          - {in_pts[1][k][COORD_BITS-1], in_pts[1][k]};
         end
         crs_ff[0][0] <= dif_ff[0][1] * dif_ff[1][2];
         crs_ff[0][1] <= dif_ff[0][2] * dif_ff[1][1];
         crs_ff[1][0] <= dif_ff[0][2] * dif_ff[1][0];
         crs_ff[1][1] <= dif_ff[0][0] * dif_ff[1][2];
         crs_ff[2][0] <= dif_ff[0][0] * dif_ff[1][1];
         crs_ff[2][1] <= dif_ff[0][1] * dif_ff[1][0];
         for (int e = 0; e < 3; e++) begin
            for (int k = 0; k < 3; k++) begin
               esq_ff[e][k] <= $unsigned(PROD_W'(dif_ff[e][k]) * PROD_W'(dif_ff[e][k]));
            end
         end
         for (int i = 0; i < 3; i++) begin
            mag_ff[i]  <= ca_in[i][MAG_W-1:0];
            esum_ff[i] <= EDGE_W'(esq_ff[i][0]) + EDGE_W'(esq_ff[i][1])
                        + EDGE_W'(esq_ff[i][2]);
            hh_ff[i]   <= hi_in[i] * hi_in[i];
            hl_ff[i]   <= hi_in[i] * lo_in[i];
            ll_ff[i]   <= lo_in[i] * lo_in[i];
            sq_ff[i]   <= (SQ_W'(hh_ff[i]) << (2 * HALF_W))
                        + (SQ_W'(hl_ff[i]) << (HALF_W + 1)) + SQ_W'(ll_ff[i]);
         end
         edge4_ff <= esum_ff[0] + esum_ff[1] + esum_ff[2];
         edge5_ff <= edge4_ff;
         edge6_ff <= edge5_ff;
         norm_ff  <= NORM_W'(sq_ff[0]) + NORM_W'(sq_ff[1]) + NORM_W'(sq_ff[2]);
      end
   end

   assign out_side = sd_ff[GEOM_STAGES-1];
   assign out_norm = norm_ff;
   assign out_edge = edge6_ff;

endmodule

[rtl/core/tsq_isqrt.sv]
// Pipelined integer square root of 12 * norm * 4^F, one root bit per stage.
// Also flags degenerate items and carries the edge sum alongside.
// Depends on tsq_pkg.
module tsq_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  tsq_pkg::side_type            in_side,
   input  logic [tsq_pkg::NORM_W-1:0]   in_norm,
   input  logic [tsq_pkg::EDGE_W-1:0]   in_edge,
   output tsq_pkg::side_type            out_side,
   output logic [tsq_pkg::R_W-1:0]      out_root,
   output logic [tsq_pkg::EDGE_W-1:0]   out_edge
);
   import tsq_pkg::*;

   logic [X_W-1:0]    x_in;
   side_type          sd_in;
   side_type          sd_ff   [R_W];
   logic [R_W-1:0]    root_ff [R_W];
   logic [EDGE_W-1:0] edge_ff [R_W];
   logic [RM_W-1:0]   rem_ff  [R_W-1];
   logic [X_W-1:0]    x_ff    [R_W-1];

   always_comb begin
      x_in  = (X_W'(in_norm) << (2 * QUALITY_FRAC_BITS + 3))
            + (X_W'(in_norm) << (2 * QUALITY_FRAC_BITS + 2));
      sd_in = in_side;
      sd_in.degen = (in_norm == '0) || (in_edge == '0);
   end

   for (genvar i = 0; i < R_W; i++) begin : g_stage
      logic [RM_W-1:0]   rem_src;
      logic [R_W-1:0]    root_src;
      logic [X_W-1:0]    x_src;
      logic [EDGE_W-1:0] edge_src;
      side_type          sd_src;
      logic [RM_W+1:0]   cur;
      logic [RM_W+1:0]   trial;
      logic              fit;

      if (i == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign x_src    = x_in;
         assign edge_src = in_edge;
         assign sd_src   = sd_in;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign x_src    = x_ff[i-1];
         assign edge_src = edge_ff[i-1];
         assign sd_src   = sd_ff[i-1];
      end

      assign cur   = {rem_src, x_src[X_W-1 -: 2]};
      assign trial = {2'b00, root_src, 2'b01};
      assign fit   = cur >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sd_ff[i].valid <= 1'b0;
         end else if (en) begin
            sd_ff[i] <= sd_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[i] <= {root_src[R_W-2:0], fit};
            edge_ff[i] <= edge_src;
         end
      end

      if (i < R_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= fit ? RM_W'(cur - trial) : cur[RM_W-1:0];
               x_ff[i]   <= x_src << 2;
            end
         end
      end
   end

   assign out_side = sd_ff[R_W-1];
   assign out_root = root_ff[R_W-1];
   assign out_edge = edge_ff[R_W-1];

endmodule

[rtl/core/tsq_div.sv]
// Pipelined restoring divider: root over edge sum, one quotient bit per stage.
// Gives the raw quality quotient with the fraction bits of the result.
// Depends on tsq_pkg.
module tsq_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  tsq_pkg::side_type            in_side,
   input  logic [tsq_pkg::R_W-1:0]      in_root,
   input  logic [tsq_pkg::EDGE_W-1:0]   in_edge,
   output tsq_pkg::side_type            out_side,
   output logic [tsq_pkg::QUO_W-1:0]    out_quo
);
   import tsq_pkg::*;

   side_type          sd_ff   [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [DV_W-1:0]   rem_ff  [QUO_W-1];
   logic [EDGE_W-1:0] edge_ff [QUO_W-1];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      logic [DV_W-1:0]   rem_src;
      logic [QUO_W-1:0]  quo_src;
      logic [EDGE_W-1:0] edge_src;
      side_type          sd_src;
      logic [DV_W-1:0]   trial;
      logic              fit;

      if (j == 0) begin : g_first
         assign rem_src  = DV_W'(in_root);
         assign quo_src  = '0;
         assign edge_src = in_edge;
         assign sd_src   = in_side;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign quo_src  = quo_ff[j-1];
         assign edge_src = edge_ff[j-1];
         assign sd_src   = sd_ff[j-1];
      end

      assign trial = DV_W'(edge_src) << (QUALITY_FRAC_BITS - j);
      assign fit   = rem_src >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sd_ff[j].valid <= 1'b0;
         end else if (en) begin
            sd_ff[j] <= sd_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[j] <= {quo_src[QUO_W-2:0], fit};
         end
      end

      if (j < QUO_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j]  <= fit ? (rem_src - trial) : rem_src;
               edge_ff[j] <= edge_src;
            end
         end
      end
   end

   assign out_side = sd_ff[QUO_W-1];
   assign out_quo  = quo_ff[QUO_W-1];

endmodule

[rtl/core/triangle_shape_quality.sv]
// Triangle shape quality top level: geometry, square root and divider stages.
// Depends on tsq_pkg, tsq_geom, tsq_isqrt and tsq_div.
//
// The block takes one triangle per cycle and returns 2*sqrt(3)*|e1 x e2| over the
// sum of squared edge lengths as unsigned Q1.16, saturated at 1.0, with a degenerate
// flag when the area or the edge sum is zero. The pipeline is built from six geometry
// stages, one stage per root bit of the 68-bit square root, one per quotient bit of
// the 17-bit divider and one output register. All stages advance together and hold
// while a result waits under rsp_stall; otherwise an item is taken every cycle.
module triangle_shape_quality (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tsq_pkg::ID_W-1:0]            req_triangle_id,
   input  logic signed [tsq_pkg::COORD_BITS-1:0] req_p0_x,
   input  logic signed [tsq_pkg::COORD_BITS-1:0] req_p0_y,
   input  logic signed [tsq_pkg::COORD_BITS-1:0] req_p0_z,
   input  logic signed [tsq_pkg::COORD_BITS-1:0] req_p1_x,
   input  logic signed [tsq_pkg::COORD_BITS-1:0] req_p1_y,
   input  logic signed [tsq_pkg::COORD_BITS-1:0] req_p1_z,
   input  logic signed [tsq_pkg::COORD_BITS-1:0] req_p2_x,
   input  logic signed [tsq_pkg::COORD_BITS-1:0] req_p2_y,
   input  logic signed [tsq_pkg::COORD_BITS-1:0] req_p2_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tsq_pkg::ID_W-1:0]            rsp_result_id,
   output logic [tsq_pkg::QUO_W-1:0]           rsp_quality,
   output logic                                rsp_degenerate
);
   import tsq_pkg::*;

   logic              en;
   side_type          req_side;
   coord_type         pts [3][3];
   side_type          geom_side, sqrt_side, div_side;
   logic [NORM_W-1:0] geom_norm;
   logic [EDGE_W-1:0] geom_edge, sqrt_edge;
   logic [R_W-1:0]    sqrt_root;
   logic [QUO_W-1:0]  div_quo;
   logic              rsp_valid_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   logic [QUO_W-1:0]  rsp_quality_ff, rsp_quality_in;
   logic              rsp_degen_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      req_side.valid = req_valid;
      req_side.degen = 1'b0;
      req_side.id    = req_triangle_id;
      pts[0][0] = req_p0_x;  pts[0][1] = req_p0_y;  pts[0][2] = req_p0_z;
      pts[1][0] = req_p1_x;  pts[1][1] = req_p1_y;  pts[1][2] = req_p1_z;
      pts[2][0] = req_p2_x;  pts[2][1] = req_p2_y;  pts[2][2] = req_p2_z;
   end

   tsq_geom u_geom (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_side  (req_side),
      .in_pts   (pts),
      .out_side (geom_side),
      .out_norm (geom_norm),
      .out_edge (geom_edge)
   );

   tsq_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_side  (geom_side),
      .in_norm  (geom_norm),
      .in_edge  (geom_edge),
      .out_side (sqrt_side),
      .out_root (sqrt_root),
      .out_edge (sqrt_edge)
   );

   tsq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_side  (sqrt_side),
      .in_root  (sqrt_root),
      .in_edge  (sqrt_edge),
      .out_side (div_side),
      .out_quo  (div_quo)
   );

   always_comb begin
      if (div_side.degen) begin
         rsp_quality_in = '0;
      end else if (div_quo > QUALITY_ONE) begin
         rsp_quality_in = QUALITY_ONE;
      end else begin
         rsp_quality_in = div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_id_ff      <= div_side.id;
         rsp_quality_ff <= rsp_quality_in;
         rsp_degen_ff   <= div_side.degen;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result_id  = rsp_id_ff;
   assign rsp_quality    = rsp_quality_ff;
   assign rsp_degenerate = rsp_degen_ff;

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_quality == '0))
      else $error("Degenerate item carries a nonzero quality.");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_quality <= QUALITY_ONE))
      else $error("Quality exceeds one.");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(div_quo) && $stable(div_side))
      else $error("Pipeline moved while a result was stalled.");

endmodule

[sim/tsq_checker.sv]
// Checker for the triangle shape quality block: watches both channels,
// predicts each result with exact wide integer arithmetic and compares in order.
// Depends on tsq_pkg for the field widths.
`timescale 1ns / 1ps
module tsq_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [tsq_pkg::ID_W-1:0]         req_triangle_id,
   input  logic [9*tsq_pkg::COORD_BITS-1:0] req_points,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [tsq_pkg::ID_W-1:0]         rsp_result_id,
   input  logic [tsq_pkg::QUO_W-1:0]        rsp_quality,
   input  logic                             rsp_degenerate,
   output int                               fail_count,
   output int                               pending,
   output int                               degen_seen,
   output int                               sat_seen
);
   import tsq_pkg::*;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [QUO_W-1:0] quality;
      logic             degen;
   } shape_result;

   shape_result quality_queue[$];

   function automatic void shape_quality(input logic [9*COORD_BITS-1:0] pts,
                                         output logic [QUO_W-1:0] q,
                                         output logic dg);
      coord_type c[9];
      logic signed [COORD_BITS:0] ax, ay, az, bx, by, bz, ex, ey, ez;
      logic signed [2*COORD_BITS+3:0] nx, ny, nz;
      logic signed [191:0] norm_sq, edge_sum;
      logic [191:0] x, t, tq;
      logic [QUO_W-1:0] acc;
      for (int i = 0; i < 9; i++) c[i] = pts[i*COORD_BITS +: COORD_BITS];
      ax = c[3] - c[0]; ay = c[4] - c[1]; az = c[5] - c[2];
      bx = c[6] - c[0]; by = c[7] - c[1]; bz = c[8] - c[2];
      ex = c[6] - c[3]; ey = c[7] - c[4]; ez = c[8] - c[5];
      nx = ay * bz - az * by;
      ny = az * bx - ax * bz;
      nz = ax * by - ay * bx;
      norm_sq = nx * nx + ny * ny + nz * nz;
      edge_sum = ax * ax + ay * ay + az * az + bx * bx + by * by + bz * bz
               + ex * ex + ey * ey + ez * ez;
      if (norm_sq == 0 || edge_sum == 0) begin
         q = '0;
         dg = 1'b1;
         return;
      end
      x = (192'(norm_sq) * 192'd12) << (2 * QUALITY_FRAC_BITS);
      acc = '0;
      for (int b = QUALITY_FRAC_BITS; b >= 0; b--) begin
         tq = 192'(acc | (QUO_W'(1) << b));
         t = tq * 192'(edge_sum);
         t = t * t;
         if (t <= x) acc = QUO_W'(tq);
      end
      if (acc > QUALITY_ONE) acc = QUALITY_ONE;
      q = acc;
      dg = 1'b0;
   endfunction

   assign pending = quality_queue.size();

   always_ff @(posedge clock) begin
      shape_result want;
      logic [QUO_W-1:0] q;
      logic dg;
      if (reset) begin
         fail_count <= 0;
         degen_seen <= 0;
         sat_seen <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            shape_quality(req_points, q, dg);
            want.id = req_triangle_id;
            want.quality = q;
            want.degen = dg;
            quality_queue.push_back(want);
            if (dg) degen_seen <= degen_seen + 1;
            if (q == QUALITY_ONE) sat_seen <= sat_seen + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (quality_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result item: id %0d quality %0d degenerate %0d",
                           rsp_result_id, rsp_quality, rsp_degenerate);
               fail_count <= fail_count + 1;
            end else begin
               want = quality_queue.pop_front();
               if (want.id !== rsp_result_id || want.quality !== rsp_quality
                   || want.degen !== rsp_degenerate) begin
                  if (fail_count < 10)
                     $display("mismatch: expected id %0d q %0d dg %0d, got id %0d q %0d dg %0d",
                              want.id, want.quality, want.degen,
                              rsp_result_id, rsp_quality, rsp_degenerate);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

[sim/testbench.sv]
// Top of the triangle shape quality testbench: clock, reset, stimulus and verdict.
// Depends on tsq_pkg, tsq_checker and the triangle_shape_quality block.
`timescale 1ns / 1ps
module testbench;
   import tsq_pkg::*;

   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [ID_W-1:0] req_triangle_id = '0;
   coord_type pt[9] = '{default: '0};
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ID_W-1:0] rsp_result_id;
   logic [QUO_W-1:0] rsp_quality;
   logic rsp_degenerate;
   logic [9*COORD_BITS-1:0] req_points;
   logic quiet = 1'b0;
   int fail_count, pending, degen_seen, sat_seen;
   int cycles = 0;
   int sent = 0;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   generate
      for (genvar g = 0; g < 9; g++) begin : g_pack
         assign req_points[g*COORD_BITS +: COORD_BITS] = pt[g];
      end
   endgenerate

   triangle_shape_quality u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_triangle_id(req_triangle_id),
      .req_p0_x(pt[0]), .req_p0_y(pt[1]), .req_p0_z(pt[2]),
      .req_p1_x(pt[3]), .req_p1_y(pt[4]), .req_p1_z(pt[5]),
      .req_p2_x(pt[6]), .req_p2_y(pt[7]), .req_p2_z(pt[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_id(rsp_result_id), .rsp_quality(rsp_quality),
      .rsp_degenerate(rsp_degenerate)
   );

   tsq_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_triangle_id(req_triangle_id), .req_points(req_points),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_id(rsp_result_id), .rsp_quality(rsp_quality),
      .rsp_degenerate(rsp_degenerate),
      .fail_count(fail_count), .pending(pending),
      .degen_seen(degen_seen), .sat_seen(sat_seen)
   );

   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_triangle(input coord_type c[9]);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_triangle_id <= ID_W'($urandom);
      for (int i = 0; i < 9; i++) pt[i] <= c[i];
      req_valid <= 1'b1;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      sent++;
   endtask

   function automatic coord_type rand_coord(input int span);
      if (span >= COORD_BITS) return coord_type'($urandom);
      return coord_type'($signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1)));
   endfunction

   initial begin
      coord_type c[9];
      coord_type a, k, d;
      int span, kind;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 9; i++) c[i] = '0;
      send_triangle(c);
      c = '{24'sd65536, 0, 0, 0, 24'sd65536, 0, 0, 0, 24'sd65536};
      send_triangle(c);
      c = '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh800000,
            24'sh800000, 24'sh7fffff, 24'sh7fffff};
      send_triangle(c);
      c = '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh7fffff,
            24'sh7fffff, 24'sh800000, 24'sh800000};
      send_triangle(c);
      c = '{24'sh800000, 0, 24'sh7fffff, 24'sh7fffff, 24'sh800000, 0,
            0, 24'sh7fffff, 24'sh800000};
      send_triangle(c);
      c = '{1, 2, 3, 1, 2, 3, 1, 2, 3};
      send_triangle(c);
      c = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
      send_triangle(c);
      c = '{24'sh800000, 24'sh800000, 24'sh800000, 0, 0, 0, 24'sh7fffff, 24'sh7fffff,
            24'sh7fffff};
      send_triangle(c);
      c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
      send_triangle(c);
      c = '{0, 0, 0, 24'sh7fffff, 0, 0, 0, 1, 0};
      send_triangle(c);
      c = '{5, 5, 5, 5, 5, 5, 6, 5, 5};
      send_triangle(c);
      c = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
      send_triangle(c);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            while (pending != 0) @(posedge clock);
         end
         if (n == RANDOM_ITEMS - 100) quiet = 1'b1;
         kind = $urandom_range(0, 9);
         span = ($urandom_range(0, 1) == 0) ? COORD_BITS : $urandom_range(2, 12);
         for (int i = 0; i < 9; i++) c[i] = rand_coord(span);
         if (kind == 0) begin
            k = coord_type'($signed($urandom_range(0, 6)) - 3);
            for (int i = 0; i < 3; i++) c[6+i] = c[i] + k * (c[3+i] - c[i]);
         end else if (kind == 1) begin
            for (int i = 0; i < 3; i++) c[3+i] = c[i];
         end else if (kind <= 3) begin
            a = coord_type'($urandom_range(1, 1 << 20));
            d = rand_coord(COORD_BITS);
            d = d >>> 2;
            c = '{d, 0, 0, d - a, a, 0, d - a, 0, a};
            for (int i = 0; i < 9; i++)
               if ($urandom_range(0, 1) == 1) c[i] = c[i] + rand_coord(3);
         end
         send_triangle(c);
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);

      $display("%0d triangles checked: %0d degenerate, %0d at full quality,",
               sent, degen_seen, sat_seen);
      $display("with random stalls on both channels and one drain pause midway.");
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, pending);
         $display("simulation failed");
      end
      $finish;
   end
endmodule
